>>> rtl/bmg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_pkg
// Shared constants, types and coefficient tables of the Gaussian transform.
// ----------------------------------------------------------------------------
package bmg_pkg;

  localparam int UNIFORM_BITS = 32;
  localparam int SAMPLE_BITS  = 32;
  localparam int OUT_BITS     = 32;

  // Sample bits that take part; the rest are cleared.
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MASK =
    (UNIFORM_BITS >= SAMPLE_BITS) ? {SAMPLE_BITS{1'b1}}
                                  : SAMPLE_BITS'((64'd1 << UNIFORM_BITS) - 64'd1);

  // Left shift that brings the angle sample to the top of a 64-bit word.
  localparam int ANGLE_SHIFT = (64 - UNIFORM_BITS) % 64;

  // 2 ln 2 in Q.32 is 2^32 + TWO_LN2_LO.
  localparam logic [31:0] TWO_LN2_LO = 32'd1659121648;
  // 2 pi in Q.32 is 6 * 2^32 + TWO_PI_LO.
  localparam logic [31:0] TWO_PI_LO  = 32'd1216271633;
  localparam logic [31:0] TWO_PI_HI  = 32'd6;

  localparam logic [2:0] COS_TERMS = 3'd7;
  localparam logic [2:0] SIN_TERMS = 3'd6;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
  } pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Division by a Horner denominator: shift out its power-of-two part, then
  // multiply by the rounded-up reciprocal of its odd part and shift down.
  // Exact for every dividend below 2^32.
  typedef struct packed {
    logic [1:0]  pre;
    logic [31:0] recip;
    logic [5:0]  post;
  } term_div_t;

  // Horner denominators, first term first.
  function automatic term_div_t term_div(input logic use_cos, input logic [2:0] idx);
    term_div_t d;
    d = '{2'd0, 32'h8000_0000, 6'd31};
    if (use_cos) begin
      unique case (idx)
        3'd0:    d = '{2'd1, 32'd3020636341, 6'd38};  // 182 = 2 * 91
        3'd1:    d = '{2'd2, 32'd4164816772, 6'd37};  // 132 = 4 * 33
        3'd2:    d = '{2'd1, 32'd3054198967, 6'd37};  // 90  = 2 * 45
        3'd3:    d = '{2'd3, 32'd2454267027, 6'd34};  // 56  = 8 * 7
        3'd4:    d = '{2'd1, 32'd2290649225, 6'd35};  // 30  = 2 * 15
        3'd5:    d = '{2'd2, 32'd2863311531, 6'd33};  // 12  = 4 * 3
        3'd6:    d = '{2'd1, 32'd2147483648, 6'd31};  // 2
        default: d = '{2'd0, 32'h8000_0000, 6'd31};
      endcase
    end else begin
      unique case (idx)
        3'd0:    d = '{2'd2, 32'd3524075731, 6'd37};  // 156 = 4 * 39
        3'd1:    d = '{2'd1, 32'd2498890064, 6'd37};  // 110 = 2 * 55
        3'd2:    d = '{2'd3, 32'd3817748708, 6'd35};  // 72  = 8 * 9
        3'd3:    d = '{2'd1, 32'd3272356036, 6'd36};  // 42  = 2 * 21
        3'd4:    d = '{2'd2, 32'd3435973837, 6'd34};  // 20  = 4 * 5
        3'd5:    d = '{2'd1, 32'd2863311531, 6'd33};  // 6   = 2 * 3
        default: d = '{2'd0, 32'h8000_0000, 6'd31};
      endcase
    end
    return d;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bmg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_front
// Drops zero samples, holds the first sample of a pair, emits whole pairs.
// ----------------------------------------------------------------------------
module bmg_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            take,
  input  wire logic [bmg_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                 push,
  output bmg_pkg::pair_t                       push_pair
);
  import bmg_pkg::*;

  logic [SAMPLE_BITS-1:0] held_r, held_nxt;
  logic                   have_r, have_nxt;
  logic [SAMPLE_BITS-1:0] v;
  logic                   nz;

  assign v  = sample & SAMPLE_MASK;
  assign nz = (v != '0);

  assign push        = take && nz && have_r;
  assign push_pair.x = held_r;
  assign push_pair.y = v;

  always_comb begin
    held_nxt = held_r;
    have_nxt = have_r;
    if (take && nz) begin
      if (have_r) begin
        have_nxt = 1'b0;
      end else begin
        held_nxt = v;
        have_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      held_r <= '0;
    end else begin
      have_r <= have_nxt;
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bmg_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_fifo
// Two-entry pair queue between the front and the back end.
// ----------------------------------------------------------------------------
module bmg_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bmg_pkg::pair_t push_pair,
  input  wire logic           pop,
  output bmg_pkg::pair_t      pop_pair,
  output bmg_pkg::fifo_stat_t stat
);
  import bmg_pkg::*;

  pair_t       mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_pair   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pair;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bmg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_back
// Sequenced transform of one pair on a shared 32x32 multiplier, with a
// bit-serial square root, reciprocal series division and an output register.
// ----------------------------------------------------------------------------
module bmg_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire bmg_pkg::fifo_stat_t          stat,
  input  wire bmg_pkg::pair_t               pop_pair,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [bmg_pkg::OUT_BITS-1:0]      out_data
);
  import bmg_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_LOG  = 4'd2;
  localparam logic [3:0] S_RAD  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_ANG  = 4'd5;
  localparam logic [3:0] S_A2   = 4'd6;
  localparam logic [3:0] S_PMUL = 4'd7;
  localparam logic [3:0] S_PDIV = 4'd8;
  localparam logic [3:0] S_SFIN = 4'd9;
  localparam logic [3:0] S_MAG  = 4'd10;

  logic [3:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] t_r, t_nxt;
  logic [4:0]  e_r, e_nxt;
  logic [31:0] frac_r, frac_nxt;
  logic [63:0] w_r, w_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [31:0] r_r, r_nxt;
  logic [29:0] h_r, h_nxt;
  logic        use_cos_r, use_cos_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] a2_r, a2_nxt;
  logic [32:0] pt_r, pt_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] dq_r, dq_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] ang_word;
  logic [31:0] p;
  logic [29:0] k;
  logic        folded;
  logic [6:0]  ub_e;
  logic [38:0] u;
  logic [63:0] rb;
  term_div_t   tdiv;
  logic [31:0] quot;
  logic [32:0] mag;

  assign pop       = (state_r == S_IDLE) && !stat.empty;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // Angle preparation from the y sample of the pair at the head.
  assign ang_word = 64'(pop_pair.y) << ANGLE_SHIFT;
  assign p        = ang_word[63:32];
  assign k        = p[29:0];
  assign folded   = (k > 30'h2000_0000);

  assign ub_e  = 7'(UNIFORM_BITS) - {2'b00, e_r};
  assign u     = {ub_e, 32'd0} - {7'd0, frac_r};
  assign rb    = res_r + bit_r;
  assign tdiv  = term_div(use_cos_r, idx_r);
  assign quot  = 32'(mul_p >> tdiv.post);
  assign mag   = {1'b0, mul_p[63:32]} + (pt_r[32] ? {1'b0, r_r} : 33'd0);

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = t_r;
    mul_b = t_r;
    unique case (state_r)
      S_RAD: begin
        mul_a = {1'b0, u[38:8]};
        mul_b = TWO_LN2_LO;
      end
      S_ANG: begin
        mul_a = {2'b00, h_r};
        mul_b = TWO_PI_LO;
      end
      S_A2: begin
        mul_a = a_r;
        mul_b = a_r;
      end
      S_PMUL: begin
        mul_a = a2_r;
        mul_b = pt_r[31:0];
      end
      S_PDIV: begin
        mul_a = dq_r >> tdiv.pre;
        mul_b = tdiv.recip;
      end
      S_SFIN: begin
        mul_a = a_r;
        mul_b = pt_r[31:0];
      end
      S_MAG: begin
        mul_a = r_r;
        mul_b = pt_r[31:0];
      end
      default: begin
        mul_a = t_r;
        mul_b = t_r;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    t_nxt       = t_r;
    e_nxt       = e_r;
    frac_nxt    = frac_r;
    w_nxt       = w_r;
    res_nxt     = res_r;
    bit_nxt     = bit_r;
    r_nxt       = r_r;
    h_nxt       = h_r;
    use_cos_nxt = use_cos_r;
    neg_nxt     = neg_r;
    a_nxt       = a_r;
    a2_nxt      = a2_r;
    pt_nxt      = pt_r;
    idx_nxt     = idx_r;
    dq_nxt      = dq_r;
    ov_nxt      = ov_r && !out_ready;
    od_nxt      = od_r;
    unique case (state_r)
      S_IDLE: begin
        if (!stat.empty) begin
          t_nxt       = pop_pair.x;
          e_nxt       = 5'd31;
          h_nxt       = folded ? 30'(31'h4000_0000 - {1'b0, k}) : k;
          use_cos_nxt = (~p[30]) != folded;
          neg_nxt     = p[31] ^ p[30];
          state_nxt   = S_NORM;
        end
      end
      S_NORM: begin
        if (t_r[31]) begin
          cnt_nxt   = 5'd31;
          frac_nxt  = '0;
          state_nxt = S_LOG;
        end else begin
          t_nxt = {t_r[30:0], 1'b0};
          e_nxt = e_r - 5'd1;
        end
      end
      S_LOG: begin
        // square the mantissa; a carry into the top bit is the next log bit
        frac_nxt = {frac_r[30:0], mul_p[63]};
        t_nxt    = mul_p[63] ? mul_p[63:32] : mul_p[62:31];
        cnt_nxt  = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = S_RAD;
        end
      end
      S_RAD: begin
        w_nxt     = (64'(u[38:8]) << 32) + mul_p;
        res_nxt   = '0;
        bit_nxt   = 64'd1 << 62;
        cnt_nxt   = 5'd31;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (w_r >= rb) begin
          w_nxt   = w_r - rb;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          r_nxt     = res_nxt[31:0];
          state_nxt = S_ANG;
        end
      end
      S_ANG: begin
        a_nxt     = 32'({2'b00, h_r} * TWO_PI_HI) + mul_p[63:32];
        state_nxt = S_A2;
      end
      S_A2: begin
        a2_nxt    = mul_p[63:32];
        pt_nxt    = 33'h1_0000_0000;
        idx_nxt   = 3'd0;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        dq_nxt    = mul_p[63:32] + (pt_r[32] ? a2_r : 32'd0);
        state_nxt = S_PDIV;
      end
      S_PDIV: begin
        // divide by the term denominator through its reciprocal
        pt_nxt  = 33'h1_0000_0000 - {1'b0, quot};
        idx_nxt = idx_r + 3'd1;
        if (idx_nxt == (use_cos_r ? COS_TERMS : SIN_TERMS)) begin
          state_nxt = use_cos_r ? S_MAG : S_SFIN;
        end else begin
          state_nxt = S_PMUL;
        end
      end
      S_SFIN: begin
        pt_nxt    = {1'b0, mul_p[63:32] + (pt_r[32] ? a_r : 32'd0)};
        state_nxt = S_MAG;
      end
      S_MAG: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          if (neg_r) begin
            od_nxt = (mag > 33'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
          end else begin
            od_nxt = (mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    t_r       <= t_nxt;
    e_r       <= e_nxt;
    frac_r    <= frac_nxt;
    w_r       <= w_nxt;
    res_r     <= res_nxt;
    bit_r     <= bit_nxt;
    r_r       <= r_nxt;
    h_r       <= h_nxt;
    use_cos_r <= use_cos_nxt;
    neg_r     <= neg_nxt;
    a_r       <= a_nxt;
    a2_r      <= a2_nxt;
    pt_r      <= pt_nxt;
    idx_r     <= idx_nxt;
    dq_r      <= dq_nxt;
    od_r      <= od_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/box_muller_gaussian_transform_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_muller_gaussian_transform_unit
// Uniform sample pairs in, one saturated Q3.28 Gaussian value per pair out.
// ----------------------------------------------------------------------------
// Back-end steps per pair: 1 to 32 normalise steps, 32 log squarings, 32
//   square-root steps, then the series terms (seven cosine terms, or six
//   sine terms and a final multiply) and the output stage.
// Throughput: one sample a cycle into a two-pair queue while it is not
//   full; the back end takes one pair at a time and takes the next only
//   once it has handed the last result to the output register.
// Reset: synchronous, active low; drop the held sample, empty the queue and
//   clear the output valid flag.
// ----------------------------------------------------------------------------
module box_muller_gaussian_transform_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [31:0] uniform_sample
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  // out_tdata: [31:0] gaussian_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata
);
  import bmg_pkg::*;

  logic       take;
  logic       push;
  pair_t      push_pair;
  pair_t      pop_pair;
  logic       pop;
  fifo_stat_t stat;

  // Hold input off while the queue is full; a completing sample needs a slot.
  assign in_tready = !stat.full;
  assign take      = in_tvalid && in_tready;

  // Front: discard zero samples and pair the rest.
  bmg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .sample    (in_tdata),
    .push      (push),
    .push_pair (push_pair)
  );

  // Queue: decouple the pairing front from the long transform.
  bmg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pair (push_pair),
    .pop       (pop),
    .pop_pair  (pop_pair),
    .stat      (stat)
  );

  // Back: log, radius, angle series and final scaling, then the output stage.
  bmg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .pop_pair  (pop_pair),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

  // A completed pair never meets a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("pair pushed into full queue");

  // The back end only takes a pair when one is queued.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pair taken from empty queue");

  // After reset nothing is queued and no result is offered.
  a_reset_clean: assert property (@(posedge clk)
    $past(!rst_n) |-> (stat.empty && !out_tvalid))
    else $error("state not cleared by reset");

endmodule
`default_nettype wire
